[hw/rtl/kth_pkg.sv]
package kth_pkg;

	// One stream value, two's complement.
	typedef logic signed [31:0] data_t;

	// Width of the rank register.
	localparam int unsigned KReqW = 11;

	// Sequencer state codes.
	localparam int unsigned StW = 3;
	localparam logic [StW-1:0] ST_IDLE = 3'd0;
	localparam logic [StW-1:0] ST_UP   = 3'd1;
	localparam logic [StW-1:0] ST_DN   = 3'd2;
	localparam logic [StW-1:0] ST_WR   = 3'd3;
	localparam logic [StW-1:0] ST_DONE = 3'd4;

endpackage

[hw/rtl/kth_largest_stream_tracker.sv]
// Keeps the k largest values of a signed 32-bit stream in a binary min-heap and
// returns, for every input request, the heap root and a full flag.
// Input channel: in_valid / in_stall / value. A request is taken when in_valid is
// high and in_stall is low. Output channel: out_valid / out_stall / kth_value /
// heap_full, one result request per input request, in order.
// Configuration channel: cfg_valid / cfg_ready / cfg_data writes the rank k.
// Write it only while the block is idle; k = 0 counts as 1 and values above
// K_MAX saturate. Lowering k does not shrink the heap.
// An append walks the heap upward and a root replacement walks it downward,
// over at most log2(K_MAX) heap levels (10 at the default); a dropped value
// goes to the output register without touching the heap. At each level the
// heap RAM returns the parent or both children in the cycle after the address,
// and the compare and write-back of the hole happen in the same cycle as the
// next read. One request is in work at a time.
// Reset clears the fill count, the sequencer and the output valid, and sets k
// to 1; the heap RAM is not cleared, since only written entries are ever read.
// While the receiver stalls, the finished result waits in the output register;
// the next input request is still taken and worked, and its result is held
// back until the output register is free.
module kth_largest_stream_tracker #(
	parameter int unsigned K_MAX = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [kth_pkg::KReqW-1:0]  cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  kth_pkg::data_t             value,
	output logic                       out_valid,
	input  logic                       out_stall,
	output kth_pkg::data_t             kth_value,
	output logic                       heap_full
);
	import kth_pkg::*;

	// Address, count and child-index widths.
	localparam int unsigned AW = (K_MAX > 1) ? $clog2(K_MAX) : 1;
	localparam int unsigned CW = $clog2(K_MAX + 1);
	localparam int unsigned PW = CW + 1;
	localparam int unsigned KW = (CW > KReqW) ? CW : KReqW;

	// Heap storage in array order.
	data_t mem [K_MAX];
	data_t rda_q;
	data_t rdb_q;

	logic [StW-1:0]   state_q;
	logic [AW-1:0]    pos_q;
	data_t            v_q;
	data_t            root_q;
	logic [CW-1:0]    fill_q;
	logic [KReqW-1:0] k_q;
	logic             out_valid_q;
	data_t            kth_value_q;
	logic             heap_full_q;

	logic [KW-1:0] k_ext;
	logic [KW-1:0] k_sat;
	logic [CW-1:0] k_eff;

	logic           in_acc;
	logic           out_free;
	logic           do_insert;
	logic           do_replace;

	logic           we;
	logic [AW-1:0]  waddr;
	data_t          wdata;
	logic           re;
	logic [AW-1:0]  ra;
	logic [AW-1:0]  rb;
	logic [StW-1:0] state_d;
	logic [AW-1:0]  pos_d;

	logic [PW-1:0]  cur_l;
	logic [PW-1:0]  cur_r;
	logic           l_ok;
	logic           r_ok;
	logic [PW-1:0]  m_idx;
	data_t          m_val;
	logic [AW-1:0]  m_addr;
	logic [PW-1:0]  nxt_l;
	logic [PW-1:0]  nxt_r;
	logic [AW-1:0]  up_par;
	logic [AW-1:0]  up_par2;
	logic [AW-1:0]  ins_par;

	function automatic logic [PW-1:0] left_of(input logic [AW-1:0] p);
		return (PW'(p) << 1) + PW'(1);
	endfunction

	function automatic logic [AW-1:0] parent_of(input logic [AW-1:0] p);
		return (p - AW'(1)) >> 1;
	endfunction

	// Effective rank: zero counts as one, and the rank saturates at K_MAX.
	assign k_ext = KW'(k_q);
	assign k_sat = (k_ext == '0) ? KW'(1) : ((k_ext > KW'(K_MAX)) ? KW'(K_MAX) : k_ext);
	assign k_eff = k_sat[CW-1:0];

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && (state_q == ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;

	// While the heap is short of k entries the value is appended; once full,
	// it replaces the root only when strictly larger.
	assign do_insert  = (fill_q < k_eff);
	assign do_replace = !do_insert && (root_q < value);

	// Children of the current hole for the sift-down.
	assign cur_l = left_of(pos_q);
	assign cur_r = cur_l + PW'(1);
	assign l_ok  = (cur_l < PW'(fill_q));
	assign r_ok  = (cur_r < PW'(fill_q));

	assign up_par  = parent_of(pos_q);
	assign up_par2 = parent_of(up_par);
	assign ins_par = parent_of(fill_q[AW-1:0]);

	// Strictly smallest of hole value and children; left wins a tie.
	always_comb begin
		m_idx = PW'(pos_q);
		m_val = v_q;
		if (l_ok && (rda_q < m_val)) begin
			m_idx = cur_l;
			m_val = rda_q;
		end
		if (r_ok && (rdb_q < m_val)) begin
			m_idx = cur_r;
			m_val = rdb_q;
		end
	end

	assign m_addr = m_idx[AW-1:0];
	assign nxt_l  = left_of(m_addr);
	assign nxt_r  = nxt_l + PW'(1);

	always_comb begin
		we      = 1'b0;
		waddr   = pos_q;
		wdata   = v_q;
		re      = 1'b0;
		ra      = '0;
		rb      = '0;
		state_d = state_q;
		pos_d   = pos_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (do_insert) begin
						if (fill_q == '0) begin
							we      = 1'b1;
							waddr   = '0;
							wdata   = value;
							state_d = ST_DONE;
						end else begin
							re      = 1'b1;
							ra      = ins_par;
							pos_d   = fill_q[AW-1:0];
							state_d = ST_UP;
						end
					end else if (do_replace) begin
						pos_d = '0;
						if (fill_q > CW'(1)) begin
							re      = 1'b1;
							ra      = AW'(1);
							rb      = (fill_q > CW'(2)) ? AW'(2) : AW'(1);
							state_d = ST_DN;
						end else begin
							we      = 1'b1;
							waddr   = '0;
							wdata   = value;
							state_d = ST_DONE;
						end
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_UP: begin
				// rda_q holds the parent of the hole.
				if (v_q < rda_q) begin
					we    = 1'b1;
					wdata = rda_q;
					pos_d = up_par;
					if (up_par == '0) begin
						state_d = ST_WR;
					end else begin
						re = 1'b1;
						ra = up_par2;
					end
				end else begin
					we      = 1'b1;
					state_d = ST_DONE;
				end
			end
			ST_DN: begin
				// rda_q and rdb_q hold the left and right children.
				if (m_idx == PW'(pos_q)) begin
					we      = 1'b1;
					state_d = ST_DONE;
				end else begin
					we    = 1'b1;
					wdata = m_val;
					pos_d = m_addr;
					if (nxt_l < PW'(fill_q)) begin
						re = 1'b1;
						ra = nxt_l[AW-1:0];
						rb = (nxt_r < PW'(fill_q)) ? nxt_r[AW-1:0] : nxt_l[AW-1:0];
					end else begin
						state_d = ST_WR;
					end
				end
			end
			ST_WR: begin
				we      = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Heap RAM: one write port, two registered read ports.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rda_q <= mem[ra];
			rdb_q <= mem[rb];
		end
	end

	// Payload registers; the root copy follows every write of entry zero.
	always_ff @(posedge clk) begin
		pos_q <= pos_d;
		if (in_acc) begin
			v_q <= value;
		end
		if (we && (waddr == '0)) begin
			root_q <= wdata;
		end
		if ((state_q == ST_DONE) && out_free) begin
			kth_value_q <= root_q;
			heap_full_q <= (fill_q >= k_eff);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			k_q         <= KReqW'(1);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				k_q <= cfg_data;
			end
			if (in_acc && do_insert) begin
				fill_q <= fill_q + CW'(1);
			end
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign kth_value = kth_value_q;
	assign heap_full = heap_full_q;

endmodule
